// ===== rtl/thwm_pkg.sv =====
// shared types and constants for the tick heartbeat window monitor
package thwm_pkg;

  localparam int unsigned TickW    = 32;
  localparam int unsigned CountW   = 32;
  localparam int unsigned ExpW     = 16;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [ExpW-1:0]     ExpReset = 16'd1000;
  localparam logic [TickW-1:0]    TickStep = 32'd1;
  localparam logic [CountW-1:0]   CountOne = 32'd1;
  localparam logic [ApbAddrW-3:0] RegExpIdx = 1'b0;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CHECK  = 1'b1
  } thwm_op_e;

  typedef enum logic {
    VERDICT_REFRESH = 1'b0,
    VERDICT_FAIL    = 1'b1
  } thwm_verdict_e;

  typedef struct packed {
    thwm_op_e         op;
    logic [TickW-1:0] tick;
  } thwm_item_t;

  typedef struct packed {
    thwm_verdict_e     verdict;
    logic [CountW-1:0] gaps;
    logic [ExpW-1:0]   expected;
    logic [CountW-1:0] good;
  } thwm_result_t;

endpackage

// ===== rtl/thwm_cfg.sv =====
// apb register file holding the expected good count per window
module thwm_cfg
  import thwm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output logic [ExpW-1:0]     expected_o
);

  logic [ExpW-1:0] exp_q;
  logic [ExpW-1:0] exp_d;
  logic            hit;

  assign pready = 1'b1;
  assign hit    = (paddr[ApbAddrW-1:2] == RegExpIdx);

  always_comb begin
    exp_d = exp_q;
    if (psel && penable && pwrite && pready && hit) begin
      exp_d = pwdata[ExpW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= ExpReset;
    end else begin
      exp_q <= exp_d;
    end
  end

  assign prdata     = hit ? {{(ApbDataW-ExpW){1'b0}}, exp_q} : '0;
  assign expected_o = exp_q;

endmodule

// ===== rtl/thwm_core.sv =====
// tick step counters, window baseline and verdict logic
module thwm_core
  import thwm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  thwm_item_t      item_i,
  input  logic [ExpW-1:0] expected_i,
  output thwm_result_t    result_o
);

  logic [TickW-1:0]  prev_q, prev_d;
  logic              have_prev_q, have_prev_d;
  logic [CountW-1:0] good_q, good_d;
  logic [CountW-1:0] gap_q, gap_d;
  logic [CountW-1:0] snap_q, snap_d;
  logic              have_base_q, have_base_d;

  logic [CountW-1:0] delta;
  logic [CountW:0]   delta_p1;
  logic [CountW:0]   exp_ext;
  logic [CountW:0]   exp_p1;
  logic              in_range;
  logic              ok;

  assign delta    = good_q - snap_q;
  assign delta_p1 = {1'b0, delta} + {{CountW{1'b0}}, 1'b1};
  assign exp_ext  = {{(CountW+1-ExpW){1'b0}}, expected_i};
  assign exp_p1   = exp_ext + {{CountW{1'b0}}, 1'b1};
  assign in_range = (delta_p1 >= exp_ext) && ({1'b0, delta} <= exp_p1);
  assign ok       = (gap_q == '0) && in_range;

  always_comb begin
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    good_d      = good_q;
    gap_d       = gap_q;
    snap_d      = snap_q;
    have_base_d = have_base_q;
    result_o    = '0;
    result_o.verdict = VERDICT_REFRESH;
    if (have_base_q && !ok) begin
      result_o.verdict  = VERDICT_FAIL;
      result_o.good     = delta;
      result_o.expected = expected_i;
      result_o.gaps     = gap_q;
    end
    if (fire_i) begin
      case (item_i.op)
        OP_SAMPLE: begin
          if (have_prev_q) begin
            if ((item_i.tick - prev_q) == TickStep) begin
              good_d = good_q + CountOne;
            end else begin
              gap_d = gap_q + CountOne;
            end
          end
          prev_d      = item_i.tick;
          have_prev_d = 1'b1;
        end
        OP_CHECK: begin
          gap_d       = '0;
          snap_d      = good_q;
          have_base_d = 1'b1;
        end
        default: begin
          prev_d = prev_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      good_q      <= '0;
      gap_q       <= '0;
      snap_q      <= '0;
      have_base_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
      good_q      <= good_d;
      gap_q       <= gap_d;
      snap_q      <= snap_d;
      have_base_q <= have_base_d;
    end
  end

endmodule

// ===== rtl/tick_heartbeat_window_monitor_top.sv =====
// top level: input register, window core and result register
//
//   channel  | dir | beat
//   s_axis   | in  | tdata = tick_value, tuser = operation
//   m_axis   | out | tdata = good, expected, gaps; tuser = verdict
//   apb      | in  | expected_good_per_window at byte address 0
//
// one beat per cycle sustained while the result register is free or the beat is a sample;
// a check's result is registered in the result register as the check leaves the input register, a sample gives none
// reset clears all counters, the baseline flag and both stage valids
// a stalled result register holds off a check in the input register and every beat behind it; a sample there passes
module tick_heartbeat_window_monitor_top
  import thwm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [TickW-1:0]    s_axis_tdata,   // [31:0] tick_value
  input  logic                s_axis_tuser,   // [0] operation
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [79:0]         m_axis_tdata,   // [31:0] good, [47:32] expected, [79:48] gaps
  output logic                m_axis_tuser,   // [0] verdict
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic            in_vld_q, in_vld_d;
  thwm_item_t      in_q, in_d;
  logic            out_vld_q, out_vld_d;
  thwm_result_t    out_q, out_d;
  thwm_result_t    res;
  logic [ExpW-1:0] expected;
  logic            out_free;
  logic            adv;

  thwm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .expected_o (expected)
  );

  thwm_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (adv),
    .item_i     (in_q),
    .expected_i (expected),
    .result_o   (res)
  );

  assign out_free      = !out_vld_q || m_axis_tready;
  assign adv           = in_vld_q && ((in_q.op == OP_SAMPLE) || out_free);
  assign s_axis_tready = !in_vld_q || adv;

  always_comb begin
    in_vld_d  = in_vld_q;
    in_d      = in_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (adv) begin
      in_vld_d = 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_vld_d = 1'b1;
      in_d.op   = thwm_op_e'(s_axis_tuser);
      in_d.tick = s_axis_tdata;
    end
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (adv && (in_q.op == OP_CHECK)) begin
      out_vld_d = 1'b1;
      out_d     = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.gaps, out_q.expected, out_q.good};
  assign m_axis_tuser  = out_q.verdict;

endmodule

// ===== tb/sv/tick_heartbeat_window_monitor_top_tb.sv =====
// self-checking testbench for the tick heartbeat window monitor: directed table, then random windows
module tick_heartbeat_window_monitor_top_tb;
  import thwm_pkg::*;

  localparam int QuietLimit   = 3000;
  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 4;
  localparam int PhaseBeats   = 220;

  localparam logic [ApbAddrW-1:0] ExpAddr   = 3'd0;
  localparam logic [ApbAddrW-1:0] SpareAddr = 3'd4;

  typedef enum logic {
    ROW_BEAT,
    ROW_WRITE
  } row_kind_e;

  typedef struct {
    row_kind_e           kind;
    thwm_op_e            op;
    logic [31:0]         data;
    logic [ApbAddrW-1:0] addr;
    bit                  typed;
    thwm_result_t        want;
  } stim_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [TickW-1:0]    s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  logic [79:0]         m_axis_tdata;
  logic                m_axis_tuser;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ApbAddrW-1:0] paddr         = '0;
  logic [ApbDataW-1:0] pwdata        = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // window monitor state as predicted
  logic [ExpW-1:0]   cfg_expected = ExpReset;
  logic [TickW-1:0]  last_tick    = '0;
  bit                seen_tick    = 1'b0;
  logic [CountW-1:0] good_total   = '0;
  logic [CountW-1:0] gap_total    = '0;
  logic [CountW-1:0] good_mark    = '0;
  bit                marked       = 1'b0;

  thwm_result_t verdicts_due[$];
  stim_row_t    stim_rows[$];

  logic [TickW-1:0] tick_cursor = '0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned beats_in       = 0;
  int unsigned verdicts_out   = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned hold_req       = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;
  thwm_result_t got_res;
  thwm_result_t want_res;

  always #6 clk_i = ~clk_i;

  tick_heartbeat_window_monitor_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  function automatic bit score_beat(input thwm_op_e op, input logic [TickW-1:0] tick,
                                    output thwm_result_t res);
    logic [CountW-1:0] gaps;
    logic [CountW-1:0] delta;
    logic [CountW:0]   gain;
    logic [CountW:0]   target;
    res = '0;
    if (op == OP_SAMPLE) begin
      if (seen_tick) begin
        if (tick - last_tick == TickStep) good_total = good_total + CountOne;
        else gap_total = gap_total + CountOne;
      end
      last_tick = tick;
      seen_tick = 1'b1;
      return 1'b0;
    end
    gaps = gap_total;
    gap_total = '0;
    if (!marked) begin
      good_mark = good_total;
      marked = 1'b1;
      return 1'b1;
    end
    delta = good_total - good_mark;
    good_mark = good_total;
    gain = {1'b0, delta};
    target = {17'b0, cfg_expected};
    if (gaps != '0 || gain + 33'd1 < target || gain > target + 33'd1) begin
      res.verdict  = VERDICT_FAIL;
      res.good     = delta;
      res.expected = cfg_expected;
      res.gaps     = gaps;
    end
    return 1'b1;
  endfunction

  function automatic void add_beat(input thwm_op_e op, input logic [31:0] tick);
    stim_row_t row;
    row = '{kind: ROW_BEAT, op: op, data: tick, addr: '0, typed: 1'b0, want: '0};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_check(input thwm_verdict_e v, input logic [CountW-1:0] good,
                                    input logic [ExpW-1:0] expv, input logic [CountW-1:0] gaps);
    stim_row_t row;
    row = '{kind: ROW_BEAT, op: OP_CHECK, data: $urandom, addr: '0, typed: 1'b1, want: '0};
    row.want.verdict  = v;
    row.want.good     = good;
    row.want.expected = expv;
    row.want.gaps     = gaps;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_write(input logic [ApbAddrW-1:0] addr, input logic [31:0] data);
    stim_row_t row;
    row = '{kind: ROW_WRITE, op: OP_SAMPLE, data: data, addr: addr, typed: 1'b0, want: '0};
    stim_rows.push_back(row);
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch in %s: expected %h, got %h", what, want, got);
  endtask

  task automatic send_beat(input thwm_op_e op, input logic [TickW-1:0] tick,
                           input bit typed, input thwm_result_t want);
    thwm_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= tick;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    beats_in++;
    if (score_beat(op, tick, res)) verdicts_due.push_back(typed ? want : res);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // write, then read register 0 back
  task automatic program_register(input logic [ApbAddrW-1:0] addr,
                                  input logic [ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr[ApbAddrW-1:2] == RegExpIdx) cfg_expected = data[ExpW-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ExpAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[ExpW-1:0] !== cfg_expected)
      flag_mismatch("register readback", 32'(cfg_expected), 32'(prdata[ExpW-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_window();
    int unsigned pick;
    int len;
    int flaw;
    int base;
    thwm_result_t none;
    none = '0;
    pick = $urandom_range(99);
    if ($urandom_range(19) == 0)
      tick_cursor = $urandom_range(1) ? $urandom : 32'hFFFF_FFF8 + $urandom_range(7);
    if (pick < 70) begin
      // mostly well-formed window around the expected count, or around a random base of up to 40 when it exceeds 40
      base = (cfg_expected > 40) ? $urandom_range(40) : cfg_expected;
      len = base + int'($urandom_range(2)) - 1;
      if ($urandom_range(7) == 0) len = len + ($urandom_range(1) ? 2 : -2);
      if (len < 0) len = 0;
      flaw = ($urandom_range(9) == 0) ? $urandom_range(len) : -1;
      for (int k = 0; k < len; k++) begin
        if (k == flaw) tick_cursor = tick_cursor + ($urandom_range(1) ? 32'd0 : $urandom);
        else tick_cursor = tick_cursor + TickStep;
        send_beat(OP_SAMPLE, tick_cursor, 1'b0, none);
      end
      send_beat(OP_CHECK, $urandom, 1'b0, none);
    end else if (pick < 85) begin
      len = $urandom_range(6, 1);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(3))
          0: tick_cursor = tick_cursor;
          1: tick_cursor = tick_cursor + TickStep;
          2: tick_cursor = tick_cursor + 32'd2;
          default: tick_cursor = $urandom;
        endcase
        send_beat(OP_SAMPLE, tick_cursor, 1'b0, none);
      end
      send_beat(OP_CHECK, $urandom, 1'b0, none);
    end else begin
      tick_cursor = $urandom;
      send_beat(thwm_op_e'($urandom_range(1)), tick_cursor, 1'b0, none);
    end
  endtask

  // result side: compare, stall, long hold on request
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      verdicts_out++;
      got_res = thwm_result_t'({m_axis_tuser, m_axis_tdata});
      if (verdicts_due.size() == 0) begin
        flag_mismatch("unexpected result beat", '0, got_res.good);
      end else begin
        want_res = verdicts_due.pop_front();
        if (got_res.verdict != want_res.verdict)
          flag_mismatch("verdict", 32'(want_res.verdict), 32'(got_res.verdict));
        if (got_res.good != want_res.good)
          flag_mismatch("good_in_window", want_res.good, got_res.good);
        if (got_res.expected != want_res.expected)
          flag_mismatch("expected_count", 32'(want_res.expected), 32'(got_res.expected));
        if (got_res.gaps != want_res.gaps)
          flag_mismatch("gaps_in_window", want_res.gaps, got_res.gaps);
      end
    end
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("tick_heartbeat_window_monitor_top_tb failed");
      $finish;
    end
  end

  initial begin
    int unsigned idle_send [4];
    int unsigned idle_recv [4];
    logic [ExpW-1:0] edge_cfgs [3];
    logic [ExpW-1:0] next_cfg;
    int unsigned phase_end;

    idle_send = '{0, 72, 0, 19};
    idle_recv = '{0, 0, 72, 19};
    edge_cfgs = '{16'd0, 16'd65535, 16'd1};

    add_check(VERDICT_REFRESH, '0, '0, '0);              // first check sets the baseline
    add_beat(OP_SAMPLE, 32'hFFFF_FFFF);                  // first sample only stores the tick
    add_beat(OP_SAMPLE, 32'h0000_0000);                  // wrapping step of one
    add_beat(OP_SAMPLE, 32'h0000_0000);
    add_beat(OP_SAMPLE, 32'h8000_0000);
    add_check(VERDICT_FAIL, 32'd1, 16'd1000, 32'd2);
    add_check(VERDICT_FAIL, 32'd0, 16'd1000, 32'd0);
    add_write(ExpAddr, 32'hFFFF_0001);
    add_beat(OP_SAMPLE, 32'h8000_0001);
    add_check(VERDICT_REFRESH, '0, '0, '0);
    add_check(VERDICT_REFRESH, '0, '0, '0);              // one short of the expected count
    add_beat(OP_SAMPLE, 32'h8000_0002);
    add_beat(OP_SAMPLE, 32'h8000_0003);
    add_beat(OP_CHECK, 32'h0000_0000);
    add_write(ExpAddr, 32'h0000_0000);                   // zero expected count
    add_check(VERDICT_REFRESH, '0, '0, '0);
    add_beat(OP_SAMPLE, 32'h8000_0004);
    add_beat(OP_SAMPLE, 32'h8000_0005);
    add_check(VERDICT_FAIL, 32'd2, 16'd0, 32'd0);
    add_write(ExpAddr, 32'h0000_FFFF);
    add_beat(OP_SAMPLE, 32'h8000_0007);
    add_check(VERDICT_FAIL, 32'd0, 16'd65535, 32'd1);
    add_write(SpareAddr, 32'h0000_0005);                 // write past the last register
    add_check(VERDICT_FAIL, 32'd0, 16'd65535, 32'd0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE) begin
        settle();
        program_register(stim_rows[i].addr, stim_rows[i].data);
      end else begin
        send_beat(stim_rows[i].op, stim_rows[i].data, stim_rows[i].typed, stim_rows[i].want);
      end
    end
    settle();
    tick_cursor = $urandom;

    for (int p = 0; p < 8; p++) begin
      send_idle_pct  = idle_send[p % 4];
      recv_stall_pct = idle_recv[p % 4];
      next_cfg = (p < 3) ? edge_cfgs[p] : ExpW'($urandom_range(12, 1));
      program_register(ExpAddr, {16'($urandom), next_cfg});
      phase_end = beats_in + PhaseBeats;
      while (beats_in < phase_end) send_window();
      settle();
    end

    // long receiver hold while the sender keeps offering beats
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    program_register(ExpAddr, {16'($urandom), ExpW'($urandom_range(8, 2))});
    hold_req++;
    phase_end = beats_in + 120;
    while (beats_in < phase_end) send_window();
    settle();

    $display("run covered %0d input beats and %0d result beats across four idling patterns",
             beats_in, verdicts_out);
    $display("expected counts 0, 1, 65535 and small random values, plus one long output hold");
    if (mismatches == 0) begin
      $display("tick_heartbeat_window_monitor_top_tb passed");
    end else begin
      $display("tick_heartbeat_window_monitor_top_tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/thwm_pkg.sv
rtl/thwm_cfg.sv
rtl/thwm_core.sv
rtl/tick_heartbeat_window_monitor_top.sv
tb/sv/tick_heartbeat_window_monitor_top_tb.sv
